FILE: rtl/subset_farthest_point_distance_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the subset farthest-point distance unit
// Shared property forms, clocked on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef SUBSET_FARTHEST_POINT_DISTANCE_UNIT_MACROS_SVH
`define SUBSET_FARTHEST_POINT_DISTANCE_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SFPD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SFPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that stays armed through reset.
`define SFPD_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/sfpd_pkg.sv
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared constants and types of the subset farthest-point distance unit.
// ----------------------------------------------------------------------------
package sfpd_pkg;

   localparam int DEF_MAX_POINTS   = 1024;
   localparam int DEF_MAX_SELECTED = 1024;
   localparam int DEF_COORD_BITS   = 16;
   localparam int DEF_FRAC_BITS    = 16;

   // Fixed field widths of the channels.
   localparam int IDX_W = 11;
   localparam int OUT_W = 33;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_POINT  = 2'd0;
   localparam kind_type KIND_SELECT = 2'd1;
   localparam kind_type KIND_START  = 2'd2;

endpackage

FILE: rtl/sfpd_if.sv
// ----------------------------------------------------------------------------
// sfpd channel interfaces
// Valid/ready channels for the request and response items.
// ----------------------------------------------------------------------------
interface sfpd_req_if
   import sfpd_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) ();
   logic                         valid;
   logic                         ready;
   kind_type                     kind;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic        [IDX_W-1:0]      select_index;

   modport source (output valid, kind, coord_x, coord_y, select_index, input ready);
   modport sink   (input valid, kind, coord_x, coord_y, select_index, output ready);
endinterface

interface sfpd_rsp_if
   import sfpd_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] max_sq_distance;
   logic [OUT_W-1:0] max_distance_fixed;
   logic             error_flag;

   modport source (output valid, max_sq_distance, max_distance_fixed, error_flag,
                   input ready);
   modport sink   (input valid, max_sq_distance, max_distance_fixed, error_flag,
                   output ready);
endinterface

FILE: rtl/sfpd_ram.sv
// ----------------------------------------------------------------------------
// sfpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sfpd_fifo.sv
// ----------------------------------------------------------------------------
// sfpd_fifo
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sfpd_fifo
   import sfpd_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/sfpd_front.sv
// ----------------------------------------------------------------------------
// sfpd_front
// Accepts request items, checks capacity, assigns store addresses and
// queues the resulting commands for the back part.
// ----------------------------------------------------------------------------
module sfpd_front
   import sfpd_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_SELECTED = DEF_MAX_SELECTED,
   parameter int COORD_BITS   = DEF_COORD_BITS,
   localparam int PCNT_W      = $clog2(MAX_POINTS + 1),
   localparam int SCNT_W      = $clog2(MAX_SELECTED + 1),
   localparam int E_W         = 3 + PCNT_W + SCNT_W + 2 * COORD_BITS + IDX_W
) (
   input  logic           clock,
   input  logic           reset,
   sfpd_req_if.sink       req_if,
   output logic           push,
   output logic [E_W-1:0] push_entry,
   input  logic           full
);

   logic              accept;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic              err_ff, err_in;

   assign req_if.ready = !full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      push    = 1'b0;
      pcnt_in = pcnt_ff;
      scnt_in = scnt_ff;
      err_in  = err_ff;
      if (accept) begin
         case (req_if.kind)
            KIND_POINT: begin
               if (pcnt_ff < PCNT_W'(MAX_POINTS)) begin
                  push    = 1'b1;
                  pcnt_in = pcnt_ff + PCNT_W'(1);
               end else begin
                  err_in = 1'b1;
               end
            end
            KIND_SELECT: begin
               if (scnt_ff < SCNT_W'(MAX_SELECTED)) begin
                  push    = 1'b1;
                  scnt_in = scnt_ff + SCNT_W'(1);
               end else begin
                  err_in = 1'b1;
               end
            end
            KIND_START: begin
               push    = 1'b1;
               pcnt_in = '0;
               scnt_in = '0;
               err_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // A start command carries the counts and the sticky error seen so far.
   assign push_entry = {req_if.kind, err_ff, pcnt_ff, scnt_ff,
                        req_if.coord_x, req_if.coord_y, req_if.select_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= '0;
         scnt_ff <= '0;
         err_ff  <= 1'b0;
      end else begin
         pcnt_ff <= pcnt_in;
         scnt_ff <= scnt_in;
         err_ff  <= err_in;
      end
   end

endmodule

FILE: rtl/sfpd_sqrt.sv
// ----------------------------------------------------------------------------
// sfpd_sqrt
// Digit-by-digit fixed point square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sfpd_sqrt
   import sfpd_pkg::*;
#(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = DEF_FRAC_BITS,
   localparam int STEPS    = (IN_W + 1) / 2 + FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [IN_W-1:0]  value,
   output logic             busy,
   output logic [STEPS-1:0] root
);

   localparam int DV_W  = 2 * STEPS;
   localparam int RM_W  = STEPS + 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DV_W-1:0]  val_ff;
   logic [RM_W-1:0]  rem_ff;
   logic [STEPS-1:0] root_ff;
   logic [RM_W-1:0]  rem_shift;
   logic [RM_W-1:0]  trial;
   logic             fits;

   assign rem_shift = {rem_ff[RM_W-3:0], val_ff[DV_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign fits      = (rem_shift >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= DV_W'(value) << (2 * FRAC_BITS);
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_W'(STEPS - 1);
      end else if (busy_ff) begin
         val_ff  <= val_ff << 2;
         rem_ff  <= fits ? rem_shift - trial : rem_shift;
         root_ff <= {root_ff[STEPS-2:0], fits};
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

FILE: rtl/sfpd_back.sv
// ----------------------------------------------------------------------------
// sfpd_back
// Executes queued commands: store writes, the selected-by-points walk with
// its distance pipeline, the square root and the response register.
// ----------------------------------------------------------------------------
module sfpd_back
   import sfpd_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_SELECTED = DEF_MAX_SELECTED,
   parameter int COORD_BITS   = DEF_COORD_BITS,
   parameter int FRAC_BITS    = DEF_FRAC_BITS,
   localparam int PCNT_W      = $clog2(MAX_POINTS + 1),
   localparam int SCNT_W      = $clog2(MAX_SELECTED + 1),
   localparam int E_W         = 3 + PCNT_W + SCNT_W + 2 * COORD_BITS + IDX_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           entry_valid,
   input  logic [E_W-1:0] entry,
   output logic           pop,
   sfpd_rsp_if.source     rsp_if
);

   localparam int C      = COORD_BITS;
   localparam int PT_AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SEL_AW = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;
   localparam int IDX_CW = (PCNT_W > IDX_W) ? PCNT_W : IDX_W;
   localparam int SQ_W   = 2 * C + 1;
   localparam int RT_W   = (SQ_W + 1) / 2 + FRAC_BITS;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SEL_RD  = 3'd1;
   localparam logic [2:0] ST_SEL_CHK = 3'd2;
   localparam logic [2:0] ST_ANCHOR  = 3'd3;
   localparam logic [2:0] ST_WALK    = 3'd4;
   localparam logic [2:0] ST_DRAIN   = 3'd5;
   localparam logic [2:0] ST_SQRT    = 3'd6;

   // Entry fields.
   kind_type          e_kind;
   logic              e_err;
   logic [PCNT_W-1:0] e_pcnt;
   logic [SCNT_W-1:0] e_scnt;
   logic [C-1:0]      e_x, e_y;
   logic [IDX_W-1:0]  e_idx;

   assign e_idx  = entry[IDX_W-1:0];
   assign e_y    = entry[IDX_W +: C];
   assign e_x    = entry[IDX_W + C +: C];
   assign e_scnt = entry[IDX_W + 2 * C +: SCNT_W];
   assign e_pcnt = entry[IDX_W + 2 * C + SCNT_W +: PCNT_W];
   assign e_err  = entry[E_W-3];
   assign e_kind = entry[E_W-1:E_W-2];

   logic [2:0]        state_ff, state_in;
   logic [PCNT_W-1:0] npts_ff, npts_in;
   logic [SCNT_W-1:0] nsel_ff, nsel_in;
   logic [SCNT_W-1:0] s_ff, s_in;
   logic [PCNT_W-1:0] j_ff, j_in;
   logic              err_ff, err_in;
   logic [C-1:0]      x1_ff, x1_in, y1_ff, y1_in;
   logic              pa_ff, pa_in, pb_ff, pc_ff;
   logic [C-1:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic [2*C-1:0]    sqx_ff, sqy_ff;
   logic [SQ_W-1:0]   max_ff, max_in;
   logic [SQ_W-1:0]   sum;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_sq_ff, rsp_fixed_ff;
   logic              rsp_err_ff;
   logic              rsp_load;

   logic              pt_rd;
   logic [PT_AW-1:0]  pt_rd_addr;
   logic [2*C-1:0]    pt_rd_data;
   logic              sel_rd;
   logic [IDX_W-1:0]  sel_rd_data;

   logic              sq_start, sq_busy;
   logic [RT_W-1:0]   sq_root;

   logic              s_last, j_last, idx_bad;
   logic [IDX_CW-1:0] idx_m1;

   logic [C:0]        ddx, ddy, ndx, ndy;

   // Stores.
   sfpd_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_pt_ram (
      .clock   (clock),
      .wr_en   (pop && e_kind == KIND_POINT),
      .wr_addr (e_pcnt[PT_AW-1:0]),
      .wr_data ({e_x, e_y}),
      .rd_en   (pt_rd),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   sfpd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SELECTED)) u_sel_ram (
      .clock   (clock),
      .wr_en   (pop && e_kind == KIND_SELECT),
      .wr_addr (e_scnt[SEL_AW-1:0]),
      .wr_data (e_idx),
      .rd_en   (sel_rd),
      .rd_addr (s_ff[SEL_AW-1:0]),
      .rd_data (sel_rd_data)
   );

   sfpd_sqrt #(.IN_W(SQ_W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (max_ff),
      .busy  (sq_busy),
      .root  (sq_root)
   );

   assign s_last  = (s_ff + SCNT_W'(1)) == nsel_ff;
   assign j_last  = (j_ff + PCNT_W'(1)) == npts_ff;
   assign idx_bad = (sel_rd_data == '0) || (IDX_CW'(sel_rd_data) > IDX_CW'(npts_ff));
   assign idx_m1  = IDX_CW'(sel_rd_data) - IDX_CW'(1);

   // Distance pipeline: absolute differences, then squares, then sum and max.
   assign ddx   = {x1_ff[C-1], x1_ff} - {pt_rd_data[2*C-1], pt_rd_data[2*C-1:C]};
   assign ddy   = {y1_ff[C-1], y1_ff} - {pt_rd_data[C-1], pt_rd_data[C-1:0]};
   assign ndx   = '0 - ddx;
   assign ndy   = '0 - ddy;
   assign dx_in = ddx[C] ? ndx[C-1:0] : ddx[C-1:0];
   assign dy_in = ddy[C] ? ndy[C-1:0] : ddy[C-1:0];
   assign sum   = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);

   always_comb begin
      state_in   = state_ff;
      npts_in    = npts_ff;
      nsel_in    = nsel_ff;
      s_in       = s_ff;
      j_in       = j_ff;
      err_in     = err_ff;
      x1_in      = x1_ff;
      y1_in      = y1_ff;
      pa_in      = 1'b0;
      max_in     = (pc_ff && sum > max_ff) ? sum : max_ff;
      pop        = 1'b0;
      pt_rd      = 1'b0;
      pt_rd_addr = j_ff[PT_AW-1:0];
      sel_rd     = 1'b0;
      sq_start   = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (entry_valid) begin
               pop = 1'b1;
               if (e_kind == KIND_START) begin
                  npts_in  = e_pcnt;
                  nsel_in  = e_scnt;
                  err_in   = e_err;
                  s_in     = '0;
                  max_in   = '0;
                  state_in = (e_scnt == '0) ? ST_DRAIN : ST_SEL_RD;
               end
            end
         end
         ST_SEL_RD: begin
            sel_rd   = 1'b1;
            state_in = ST_SEL_CHK;
         end
         ST_SEL_CHK: begin
            if (idx_bad) begin
               err_in   = 1'b1;
               s_in     = s_ff + SCNT_W'(1);
               state_in = s_last ? ST_DRAIN : ST_SEL_RD;
            end else begin
               pt_rd      = 1'b1;
               pt_rd_addr = idx_m1[PT_AW-1:0];
               state_in   = ST_ANCHOR;
            end
         end
         ST_ANCHOR: begin
            x1_in    = pt_rd_data[2*C-1:C];
            y1_in    = pt_rd_data[C-1:0];
            j_in     = '0;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            pt_rd = 1'b1;
            pa_in = 1'b1;
            if (j_last) begin
               s_in     = s_ff + SCNT_W'(1);
               state_in = s_last ? ST_DRAIN : ST_SEL_RD;
            end else begin
               j_in = j_ff + PCNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!(pa_ff || pb_ff || pc_ff)) begin
               sq_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!sq_busy && (!rsp_valid_ff || rsp_if.ready)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pa_ff        <= 1'b0;
         pb_ff        <= 1'b0;
         pc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pa_ff        <= pa_in;
         pb_ff        <= pa_ff;
         pc_ff        <= pb_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      npts_ff <= npts_in;
      nsel_ff <= nsel_in;
      s_ff    <= s_in;
      j_ff    <= j_in;
      err_ff  <= err_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      max_ff  <= max_in;
      if (rsp_load) begin
         rsp_sq_ff    <= OUT_W'(max_ff);
         rsp_fixed_ff <= OUT_W'(sq_root);
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.max_sq_distance    = rsp_sq_ff;
   assign rsp_if.max_distance_fixed = rsp_fixed_ff;
   assign rsp_if.error_flag         = rsp_err_ff;

endmodule

FILE: rtl/subset_farthest_point_distance_unit.sv
// ----------------------------------------------------------------------------
// subset_farthest_point_distance_unit
// Largest squared distance from a selected subset of 2D points to all points.
// ----------------------------------------------------------------------------
// The req_if channel carries one item per handshake: kind 0 loads a point,
// kind 1 loads a 1-based selected index, kind 2 starts the computation and
// kind 3 is ignored. Only a start item produces an item on rsp_if, carrying
// the largest squared distance, its square root in unsigned fixed point with
// FRAC_BITS fraction bits (truncated) and the error flag.
// Load items are taken one per cycle; the front part only needs a free slot
// in the four-entry command queue, so loads keep flowing while a result waits.
// While a start item runs, the walk reads the point store once per cycle,
// all points for each valid selection, and the square root yields one
// bit per cycle.
// Reset (synchronous, active high) clears the counts, the error flag, the
// queue and the response valid bit; the stores keep their contents.
// When the receiver stalls, the response is held in its register; the back
// part then waits only before delivering the next result, and the front part
// stalls once the queue is full.
// ----------------------------------------------------------------------------
module subset_farthest_point_distance_unit
   import sfpd_pkg::*;
#(
   parameter int MAX_POINTS   = DEF_MAX_POINTS,
   parameter int MAX_SELECTED = DEF_MAX_SELECTED,
   parameter int COORD_BITS   = DEF_COORD_BITS,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   sfpd_req_if.sink   req_if,
   sfpd_rsp_if.source rsp_if
);

   // Width of one queued command: kind, sticky error, both counts (or the
   // store address for a load), the coordinates and the selected index.
   localparam int PCNT_W = $clog2(MAX_POINTS + 1);
   localparam int SCNT_W = $clog2(MAX_SELECTED + 1);
   localparam int E_W    = 3 + PCNT_W + SCNT_W + 2 * COORD_BITS + IDX_W;

   logic           q_push;
   logic [E_W-1:0] q_push_entry;
   logic           q_full;
   logic           q_pop;
   logic [E_W-1:0] q_pop_entry;
   logic           q_empty;

   // Front part: takes items, counts the loads and flags overflowing ones.
   sfpd_front #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_SELECTED (MAX_SELECTED),
      .COORD_BITS   (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full)
   );

   // Command queue between the two parts.
   sfpd_fifo #(
      .WIDTH (E_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_entry),
      .empty     (q_empty)
   );

   // Back part: stores, distance walk, square root and response register.
   sfpd_back #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_SELECTED (MAX_SELECTED),
      .COORD_BITS   (COORD_BITS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!q_empty),
      .entry       (q_pop_entry),
      .pop         (q_pop),
      .rsp_if      (rsp_if)
   );

endmodule

FILE: rtl/sfpd_checker.sv
// ----------------------------------------------------------------------------
// sfpd_checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "subset_farthest_point_distance_unit_macros.svh"

module sfpd_checker
   import sfpd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_max_sq_distance,
   input logic [OUT_W-1:0] rsp_max_distance_fixed,
   input logic             rsp_error_flag
);

   localparam int IP_W = OUT_W - DEF_FRAC_BITS;
   localparam int SQ_W = 2 * (IP_W + 1);

   logic [IP_W-1:0] int_part;
   logic [SQ_W-1:0] int_sq;
   logic [SQ_W-1:0] next_sq;
   logic [SQ_W-1:0] dist_sq;

   // Integer part of the root must satisfy r*r <= d < (r+1)*(r+1).
   always_comb begin
      int_part = rsp_max_distance_fixed[OUT_W-1:DEF_FRAC_BITS];
      int_sq   = SQ_W'(int_part) * SQ_W'(int_part);
      next_sq  = (SQ_W'(int_part) + SQ_W'(1)) * (SQ_W'(int_part) + SQ_W'(1));
      dist_sq  = SQ_W'(rsp_max_sq_distance);
   end

   `SFPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_max_sq_distance) && $stable(rsp_max_distance_fixed)
      && $stable(rsp_error_flag), "stalled response item changed")
   `SFPD_ASSERT_RESET(a_rsp_reset, $past(reset), !rsp_valid,
      "response valid right after reset")
   `SFPD_ASSERT_IMP(a_root_low, rsp_valid, int_sq <= dist_sq,
      "square root too large for the squared distance")
   `SFPD_ASSERT_IMP(a_root_high, rsp_valid, next_sq > dist_sq,
      "square root too small for the squared distance")

endmodule

bind subset_farthest_point_distance_unit sfpd_checker u_sfpd_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_if.valid),
   .rsp_ready              (rsp_if.ready),
   .rsp_max_sq_distance    (rsp_if.max_sq_distance),
   .rsp_max_distance_fixed (rsp_if.max_distance_fixed),
   .rsp_error_flag         (rsp_if.error_flag)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subset farthest-point distance unit: sends
// point, selection and start items, predicts every result and checks it.
// ----------------------------------------------------------------------------
module tb_top;
   import sfpd_pkg::*;

   // ------------------------------------------------------------------------
   // Bench constants. The widths follow the defaults of the package, which
   // are also the parameters the unit is built with here.
   // ------------------------------------------------------------------------
   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 4;
   localparam int COORD_W        = DEF_COORD_BITS;
   localparam int FRAC_W         = DEF_FRAC_BITS;
   localparam int MAX_POINTS     = DEF_MAX_POINTS;
   localparam int MAX_SELECTED   = DEF_MAX_SELECTED;
   localparam int RANDOM_ITEMS   = 300;
   localparam int LONG_HOLD_OFF  = 600;
   localparam int TAIL_CYCLES    = 200;
   // The slowest start (a full selection store over two points) plus the long
   // hold-off, taken several times over.
   localparam int WATCHDOG_LIMIT = 40000;

   // The package leaves the fourth kind unnamed; the unit ignores it.
   localparam kind_type KIND_IGNORED = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [IDX_W-1:0]          index_type;

   localparam coord_type COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   typedef struct packed {
      logic [OUT_W-1:0] square_distance;
      logic [OUT_W-1:0] root_fixed;
      logic             error_flag;
   } distance_result_type;

   // ------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the point and selection stores,
   // works out the result of every start item when that item is accepted,
   // and compares each delivered result with the oldest one still waiting.
   // ------------------------------------------------------------------------
   class farthest_distance_scoreboard;
      coord_type           point_x[MAX_POINTS];
      coord_type           point_y[MAX_POINTS];
      index_type           chosen_index[MAX_SELECTED];
      int unsigned         point_total;
      int unsigned         chosen_total;
      bit                  capacity_fault;
      distance_result_type expected_results[$];
      int unsigned         failures;
      int unsigned         results_checked;
      int unsigned         flagged_results;

      function new();
         point_total     = 0;
         chosen_total    = 0;
         capacity_fault  = 1'b0;
         failures        = 0;
         results_checked = 0;
         flagged_results = 0;
      endfunction

      // Square root scaled by 2^FRAC_W and truncated, found one result bit at
      // a time from the top: a bit stays set while the square of the partial
      // root does not exceed the scaled square.
      function logic [OUT_W-1:0] fixed_root(logic [OUT_W-1:0] square);
         logic [71:0]    scaled;
         logic [71:0]    trial;
         logic [OUT_W:0] root;
         int             b;
         scaled = 72'(square) << (2 * FRAC_W);
         root   = '0;
         for (b = OUT_W; b >= 0; b--) begin
            trial    = 72'(root);
            trial[b] = 1'b1;
            if (trial * trial <= scaled) root[b] = 1'b1;
         end
         return root[OUT_W-1:0];
      endfunction

      // Every valid selected point against every stored point.
      function distance_result_type farthest_distance();
         distance_result_type result;
         longint              best;
         longint              dx;
         longint              dy;
         longint              sq;
         int unsigned         s;
         int unsigned         j;
         int unsigned         anchor;
         best              = 0;
         result.error_flag = capacity_fault;
         for (s = 0; s < chosen_total; s++) begin
            anchor = chosen_index[s];
            if (anchor == 0 || anchor > point_total) begin
               result.error_flag = 1'b1;
            end else begin
               for (j = 0; j < point_total; j++) begin
                  dx = longint'(point_x[anchor-1]) - longint'(point_x[j]);
                  dy = longint'(point_y[anchor-1]) - longint'(point_y[j]);
                  sq = dx * dx + dy * dy;
                  if (sq > best) best = sq;
               end
            end
         end
         result.square_distance = OUT_W'(best);
         result.root_fixed      = fixed_root(OUT_W'(best));
         return result;
      endfunction

      function void note_request(kind_type kind, coord_type x, coord_type y,
                                 index_type idx);
         case (kind)
            KIND_POINT: begin
               if (point_total < MAX_POINTS) begin
                  point_x[point_total] = x;
                  point_y[point_total] = y;
                  point_total++;
               end else begin
                  capacity_fault = 1'b1;
               end
            end
            KIND_SELECT: begin
               if (chosen_total < MAX_SELECTED) begin
                  chosen_index[chosen_total] = idx;
                  chosen_total++;
               end else begin
                  capacity_fault = 1'b1;
               end
            end
            KIND_START: begin
               expected_results.insert(expected_results.size(), farthest_distance());
               point_total    = 0;
               chosen_total   = 0;
               capacity_fault = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [OUT_W-1:0] sq, logic [OUT_W-1:0] root,
                                 logic flag);
         distance_result_type want;
         if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected result: squared %0d, root %0d, error %b",
                     $time, sq, root, flag);
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (want.error_flag) flagged_results++;
         if (sq !== want.square_distance) begin
            failures++;
            $display("%0t: squared distance mismatch: expected %0d, actual %0d",
                     $time, want.square_distance, sq);
         end
         if (root !== want.root_fixed) begin
            failures++;
            $display("%0t: fixed-point root mismatch: expected %0d, actual %0d",
                     $time, want.root_fixed, root);
         end
         if (flag !== want.error_flag) begin
            failures++;
            $display("%0t: error flag mismatch: expected %b, actual %b",
                     $time, want.error_flag, flag);
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, channels and the unit itself.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   sfpd_req_if #(.COORD_BITS(COORD_W)) req_if ();
   sfpd_rsp_if                         rsp_if ();

   subset_farthest_point_distance_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   farthest_distance_scoreboard sb = new();

   // Idling odds in percent, changed by the stimulus process between phases.
   int unsigned sender_idle_pct   = 32;
   int unsigned receiver_idle_pct = 46;
   // Set by the stimulus to ask the receiver for one long hold-off; the
   // receiver counts the cycles itself.
   int unsigned hold_off_request  = 0;
   int unsigned accepted_items    = 0;

   // ------------------------------------------------------------------------
   // Receiver: ready is drawn afresh every cycle, apart from the one long
   // hold-off during which it stays low while items keep arriving upstream.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int unsigned stall_length;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            stall_length     = hold_off_request;
            hold_off_request = 0;
            rsp_if.ready    <= 1'b0;
            repeat (stall_length) @(posedge clock);
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Every delivered result is checked at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_result(rsp_if.max_sq_distance, rsp_if.max_distance_fixed,
                         rsp_if.error_flag);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run once no item has moved on either channel for
   // too long, which also catches a result that never arrives.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no item moved for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sender. One call offers one item, with random idle cycles in front of
   // it, and returns at the edge where it is accepted. Valid is left high so
   // that a following call in the same time step simply replaces the payload.
   // ------------------------------------------------------------------------
   task automatic send_item(input kind_type kind, input coord_type x,
                            input coord_type y, input index_type idx);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.coord_x      <= x;
      req_if.coord_y      <= y;
      req_if.select_index <= idx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(kind, x, y, idx);
      if (kind != KIND_IGNORED) accepted_items++;
   endtask

   // Drops valid and holds off until every predicted result has come back.
   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Full-range values most of the time, a tight cluster for near-ties, or
   // only the two ends of the coordinate range, minus one and zero.
   function automatic coord_type random_coord(input int unsigned mode);
      if (mode < 6) return coord_type'($urandom);
      if (mode < 8) return coord_type'(int'($urandom_range(0, 16)) - 8);
      case ($urandom_range(0, 3))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '1;
         default: return '0;
      endcase
   endfunction

   // Mostly an index into the set being built, else zero, just past the
   // loaded points, or anything the field can carry.
   function automatic index_type random_index(input int unsigned point_total);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (point_total > 0 && roll < 80) return index_type'($urandom_range(1, point_total));
      if (roll < 87) return '0;
      if (roll < 94) return index_type'(point_total + $urandom_range(1, 4));
      return index_type'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // Directed items: corners of the coordinate range, a bad index of every
   // sort, the ignored kind, a lone point, an empty start and a start with
   // selections but no points. Under two dozen items in all.
   // ------------------------------------------------------------------------
   task automatic run_directed();
      // Nothing loaded: both distances are zero and no error is raised.
      send_item(KIND_START, '0, '0, '0);
      // Opposite corners give the largest distance the fields can hold.
      send_item(KIND_POINT, COORD_MIN, COORD_MIN, '0);
      send_item(KIND_POINT, COORD_MAX, COORD_MAX, '0);
      send_item(KIND_IGNORED, COORD_MAX, COORD_MIN, '1);
      send_item(KIND_SELECT, '0, '0, index_type'(1));
      send_item(KIND_SELECT, '0, '0, '0);
      send_item(KIND_SELECT, '0, '0, index_type'(3));
      send_item(KIND_SELECT, '1, '1, '1);
      send_item(KIND_START, '0, '0, '0);
      // A 3-4-5 triangle gives an exact root; the flag must have cleared.
      send_item(KIND_POINT, '0, '0, '0);
      send_item(KIND_POINT, coord_type'(3), coord_type'(4), '0);
      send_item(KIND_SELECT, '0, '0, index_type'(2));
      send_item(KIND_START, '0, '0, '0);
      // A single point against itself.
      send_item(KIND_POINT, coord_type'(-5), coord_type'(7), '0);
      send_item(KIND_SELECT, '0, '0, index_type'(1));
      send_item(KIND_START, '0, '0, '0);
      // Alternating bit patterns, and the top of the index range unloaded.
      send_item(KIND_POINT, coord_type'(16'h5555), coord_type'(16'haaaa), '0);
      send_item(KIND_POINT, coord_type'(16'haaaa), coord_type'(16'h5555), '0);
      send_item(KIND_SELECT, '0, '0, index_type'(1));
      send_item(KIND_SELECT, '0, '0, index_type'(MAX_POINTS));
      send_item(KIND_START, '0, '0, '0);
      // Selections with no points at all.
      send_item(KIND_SELECT, '0, '0, index_type'(2));
      send_item(KIND_START, '0, '0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Capacity: each store is overfilled by one item in a set of its own, so
   // that either overflow alone has to raise the error flag.
   // ------------------------------------------------------------------------
   task automatic run_capacity_sets();
      int unsigned k;
      for (k = 0; k < MAX_POINTS; k++) begin
         send_item(KIND_POINT, coord_type'(int'($urandom_range(0, 2000)) - 1000),
                   coord_type'(int'($urandom_range(0, 2000)) - 1000),
                   index_type'($urandom));
      end
      // This point is dropped; were it kept it would set the maximum.
      send_item(KIND_POINT, COORD_MAX, COORD_MIN, '0);
      send_item(KIND_SELECT, '0, '0, index_type'(MAX_POINTS));
      send_item(KIND_START, '0, '0, '0);
      // Two points and one selection more than the store can hold.
      send_item(KIND_POINT, coord_type'(100), coord_type'(-100), '0);
      send_item(KIND_POINT, coord_type'(-100), coord_type'(100), '0);
      for (k = 0; k <= MAX_SELECTED; k++) begin
         send_item(KIND_SELECT, coord_type'($urandom), coord_type'($urandom),
                   index_type'($urandom_range(1, 2)));
      end
      send_item(KIND_START, '0, '0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Random sets: points and selections in shuffled order, then a start.
   // Most sets are small so that the walk stays short; a few are larger.
   // The odd ignored item is mixed in and not counted towards the goal.
   // ------------------------------------------------------------------------
   task automatic run_random_sets(input int unsigned item_goal, input bit with_hold_off);
      int unsigned sent;
      int unsigned roll;
      int unsigned set_points;
      int unsigned points_left;
      int unsigned selections_left;
      int unsigned coord_mode;
      bit          hold_done;
      sent      = 0;
      hold_done = 1'b0;
      while (sent < item_goal) begin
         if (with_hold_off && !hold_done && sent >= item_goal / 3) begin
            hold_off_request = LONG_HOLD_OFF;
            hold_done        = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 90)      set_points = $urandom_range(1, 12);
         else if (roll < 97) set_points = $urandom_range(13, 64);
         else if (roll < 99) set_points = $urandom_range(65, 300);
         else                set_points = 0;
         selections_left = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 5);
         points_left     = set_points;
         coord_mode      = $urandom_range(0, 9);
         while (points_left + selections_left > 0) begin
            if ($urandom_range(0, 99) < 3) begin
               send_item(KIND_IGNORED, coord_type'($urandom), coord_type'($urandom),
                         index_type'($urandom));
            end
            if (selections_left == 0 || (points_left > 0 &&
                $urandom_range(0, points_left + selections_left - 1) < points_left)) begin
               send_item(KIND_POINT, random_coord(coord_mode), random_coord(coord_mode),
                         index_type'($urandom));
               points_left--;
            end else begin
               send_item(KIND_SELECT, coord_type'($urandom), coord_type'($urandom),
                         random_index(set_points));
               selections_left--;
            end
            sent++;
         end
         send_item(KIND_START, coord_type'($urandom), coord_type'($urandom),
                   index_type'($urandom));
         sent++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence. Reset once, then the directed and capacity items and
   // three random phases with different idling: sender idling less than the
   // receiver, then the reverse, then no idling at all. The first random
   // phase includes the long receiver hold-off, and the sender waits for
   // every outstanding result between phases.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.kind         <= KIND_POINT;
      req_if.coord_x      <= '0;
      req_if.coord_y      <= '0;
      req_if.select_index <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_for_results();
      run_capacity_sets();
      wait_for_results();
      run_random_sets(RANDOM_ITEMS / 3, 1'b1);
      wait_for_results();

      sender_idle_pct   = 46;
      receiver_idle_pct = 32;
      run_random_sets(RANDOM_ITEMS / 3, 1'b0);
      wait_for_results();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random_sets(RANDOM_ITEMS / 3, 1'b0);
      wait_for_results();

      // Allow time for any stray result to show up before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d load and start items: corner values, both stores",
               accepted_items);
      $display("overfilled, random sets under three idling patterns and a long hold-off.");
      $display("%0d results checked, %0d of them flagged.",
               sb.results_checked, sb.flagged_results);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
